>>> design/tcv_pkg.sv
package tcv_pkg;

   localparam int CODE_W = 31;

   // byte class boundaries
   localparam logic [7:0] BYTE_LEAD_MIN  = 8'hc2;
   localparam logic [7:0] BYTE_LEAD3_MIN = 8'he0;
   localparam logic [7:0] BYTE_LEAD4_MIN = 8'hf0;
   localparam logic [7:0] BYTE_LEAD5_MIN = 8'hf8;
   localparam logic [7:0] BYTE_LEAD6_MIN = 8'hfc;
   localparam logic [7:0] BYTE_BAD_MIN   = 8'hfe;
   localparam logic [7:0] BYTE_CONT_MASK = 8'h3f;
   localparam logic [7:0] BYTE_ASCII_LIM = 8'h80;
   localparam logic [7:0] LATIN_MIN      = 8'd160;

   // code point limits
   localparam logic [CODE_W-1:0] CP_SURR_BASE = 31'h0000_d800;
   localparam logic [CODE_W-1:0] CP_SURR_MASK = 31'h0000_07ff;
   localparam logic [CODE_W-1:0] CP_BOM       = 31'h0000_feff;
   localparam logic [CODE_W-1:0] CP_NONCHAR0  = 31'h0000_fffe;
   localparam logic [CODE_W-1:0] CP_NONCHAR1  = 31'h0000_ffff;
   localparam logic [CODE_W-1:0] CP_LATIN_MIN = 31'd160;

   // sequence lengths
   localparam logic [2:0] SEQ_NONE = 3'd0;
   localparam logic [2:0] SEQ_LEN2 = 3'd2;
   localparam logic [2:0] SEQ_LEN3 = 3'd3;
   localparam logic [2:0] SEQ_LEN4 = 3'd4;
   localparam logic [2:0] SEQ_LEN5 = 3'd5;
   localparam logic [2:0] SEQ_LEN6 = 3'd6;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_string;
   } tcv_req_type;

   typedef struct packed {
      logic ascii_ok;
      logic latin1_ok;
      logic utf8_ok;
   } tcv_rsp_type;

   typedef struct packed {
      logic              ascii_good;
      logic              latin_good;
      logic              utf_good;
      logic [2:0]        bytes_pending;
      logic [2:0]        sequence_length;
      logic [CODE_W-1:0] code_accum;
   } tcv_state_type;

   localparam tcv_state_type STATE_RESET = '{
      ascii_good:      1'b1,
      latin_good:      1'b1,
      utf_good:        1'b1,
      bytes_pending:   3'd0,
      sequence_length: 3'd0,
      code_accum:      '0
   };

   // tab, lf, cr and printable range
   function automatic logic text_char_ok(input logic [CODE_W-1:0] c);
      text_char_ok = (c >= 31'd32 && c < 31'd127) || c == 31'd9 || c == 31'd10
                     || c == 31'd13;
   endfunction

   function automatic logic code_point_ok(input logic [CODE_W-1:0] c);
      code_point_ok = text_char_ok(c)
                      || (c >= CP_LATIN_MIN && (c & ~CP_SURR_MASK) != CP_SURR_BASE
                          && c != CP_BOM && c != CP_NONCHAR0 && c != CP_NONCHAR1);
   endfunction

endpackage

>>> design/tcv_step.sv
module tcv_step import tcv_pkg::*; (
   input  tcv_state_type cur,
   input  tcv_req_type   word,
   output tcv_state_type nxt,
   output tcv_rsp_type   result
);

   logic [7:0]        b;
   logic [CODE_W-1:0] b_ext;
   logic [CODE_W-1:0] code_shift;
   logic [2:0]        pending_dec;
   logic              overlong;
   tcv_state_type     upd;

   assign b           = word.text_byte;
   assign b_ext       = CODE_W'(b);
   assign code_shift  = {cur.code_accum[CODE_W-7:0], b[5:0]};
   assign pending_dec = cur.bytes_pending - 3'd1;

   // value below the smallest allowed for its length
   always_comb begin
      unique case (cur.sequence_length)
         SEQ_LEN3: overlong = code_shift[CODE_W-1:11] == '0;
         SEQ_LEN4: overlong = code_shift[CODE_W-1:16] == '0;
         SEQ_LEN5: overlong = code_shift[CODE_W-1:21] == '0;
         SEQ_LEN6: overlong = code_shift[CODE_W-1:26] == '0;
         default:  overlong = 1'b0;
      endcase
   end

   // per-byte verdict update
   always_comb begin
      upd = cur;
      if (!text_char_ok(b_ext)) upd.ascii_good = 1'b0;
      if (!(text_char_ok(b_ext) || b >= LATIN_MIN)) upd.latin_good = 1'b0;

      if (cur.bytes_pending != 3'd0) begin
         if (b[7:6] != 2'b10) begin
            // broken continuation drops the open sequence
            upd.utf_good        = 1'b0;
            upd.bytes_pending   = 3'd0;
            upd.sequence_length = SEQ_NONE;
            upd.code_accum      = '0;
         end else begin
            upd.code_accum    = code_shift;
            upd.bytes_pending = pending_dec;
            if (pending_dec == 3'd0) begin
               if (!code_point_ok(code_shift) || overlong) upd.utf_good = 1'b0;
               upd.sequence_length = SEQ_NONE;
               upd.code_accum      = '0;
            end
         end
      end else if (b < BYTE_ASCII_LIM) begin
         if (!code_point_ok(b_ext)) upd.utf_good = 1'b0;
      end else if (b < BYTE_LEAD_MIN || b >= BYTE_BAD_MIN) begin
         upd.utf_good = 1'b0;
      end else begin
         // lead byte opens a sequence
         priority if (b < BYTE_LEAD3_MIN) begin
            upd.sequence_length = SEQ_LEN2;
            upd.code_accum      = CODE_W'(b[4:0]);
         end else if (b < BYTE_LEAD4_MIN) begin
            upd.sequence_length = SEQ_LEN3;
            upd.code_accum      = CODE_W'(b[3:0]);
         end else if (b < BYTE_LEAD5_MIN) begin
            upd.sequence_length = SEQ_LEN4;
            upd.code_accum      = CODE_W'(b[2:0]);
         end else if (b < BYTE_LEAD6_MIN) begin
            upd.sequence_length = SEQ_LEN5;
            upd.code_accum      = CODE_W'(b[1:0]);
         end else begin
            upd.sequence_length = SEQ_LEN6;
            upd.code_accum      = CODE_W'(b[0]);
         end
         upd.bytes_pending = upd.sequence_length - 3'd1;
      end
   end

   // verdicts on the last byte, then fresh state for the next string
   always_comb begin
      result.ascii_ok  = upd.ascii_good;
      result.latin1_ok = upd.latin_good;
      result.utf8_ok   = upd.utf_good && upd.bytes_pending == 3'd0;
      nxt = word.end_of_string ? STATE_RESET : upd;
   end

endmodule

>>> design/text_charset_validator.sv
// A final byte passes the input register and then the result register (two
// register stages) before its verdict word shows on rsp_valid/rsp_data.
// Throughput: one byte per cycle, set by the single-pass decode, unless a
// final byte waits on a result register that rsp_stall holds full.
// Reset: synchronous, active high; clears both register valid bits and the
// decoder state to the start-of-string verdicts.
module text_charset_validator import tcv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  tcv_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output tcv_rsp_type rsp_data
);

   logic          in_valid_ff, in_valid_in;
   tcv_req_type   in_word_ff, in_word_in;
   logic          out_valid_ff, out_valid_in;
   tcv_rsp_type   out_word_ff, out_word_in;
   tcv_state_type state_ff, state_in;
   tcv_state_type step_state;
   tcv_rsp_type   step_result;
   logic          consume;
   logic          req_take;

   tcv_step u_step (
      .cur    (state_ff),
      .word   (in_word_ff),
      .nxt    (step_state),
      .result (step_result)
   );

   // a held byte moves on unless it is a final byte and the result register is full and stalled
   assign consume  = in_valid_ff
                     && (!in_word_ff.end_of_string || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !consume;
   assign req_take  = req_valid && !req_stall;

   // next values for input register, decoder state and result register
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_word_in   = in_word_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      state_in     = state_ff;
      if (consume) begin
         in_valid_in = 1'b0;
         state_in    = step_state;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_word_in  = req_data;
      end
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      if (consume && in_word_ff.end_of_string) begin
         out_valid_in = 1'b1;
         out_word_in  = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

   // an open sequence always has a length, and nothing pending means none open
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.bytes_pending == 3'd0) == (state_ff.sequence_length == SEQ_NONE))
      else $error("pending count and sequence length disagree");

   assert property (@(posedge clock) disable iff (reset)
      state_ff.sequence_length == SEQ_NONE
      || state_ff.bytes_pending < state_ff.sequence_length)
      else $error("more bytes pending than the sequence holds");

   // good ascii is a subset of good latin-1
   assert property (@(posedge clock) disable iff (reset)
      state_ff.ascii_good |-> state_ff.latin_good)
      else $error("ascii verdict good while latin-1 verdict bad");

   // a result word only follows a final byte leaving the input register
   assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff ##1 out_valid_ff |-> $past(consume && in_word_ff.end_of_string))
      else $error("result word without a final byte");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import tcv_pkg::*;

   // run shape
   localparam int RANDOM_BYTES   = 1200;
   localparam int DIRECTED_ROWS  = 26;
   localparam int HOLD_FROM      = 400;
   localparam int HOLD_TO        = 650;
   localparam int CALM_FROM      = 800;
   localparam int CALM_TO        = 1100;
   localparam int IDLE_PERCENT   = 8;
   localparam int DRAIN_CYCLES   = 20;

   typedef struct {
      logic [7:0]  text_byte;
      logic        last;
      logic        typed;
      tcv_rsp_type want;
   } directed_row_type;

   typedef struct {
      tcv_req_type word;
      logic        typed;
      tcv_rsp_type want;
   } feed_entry_type;

   // directed bytes; typed verdicts are {ascii, latin1, utf8}
   directed_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{8'h41, 1'b1, 1'b1, 3'b111},   // plain letter
      '{8'h00, 1'b1, 1'b1, 3'b000},   // zero byte clears everything
      '{8'h09, 1'b0, 1'b0, 3'b000},   // tab
      '{8'h0a, 1'b0, 1'b0, 3'b000},   // line feed
      '{8'h0d, 1'b0, 1'b0, 3'b000},   // carriage return
      '{8'h20, 1'b0, 1'b0, 3'b000},   // space
      '{8'h7e, 1'b1, 1'b1, 3'b111},   // top of printable range
      '{8'h7f, 1'b1, 1'b1, 3'b000},   // delete
      '{8'h80, 1'b1, 1'b1, 3'b000},   // stray continuation
      '{8'hc1, 1'b1, 1'b1, 3'b010},   // lead byte too low
      '{8'hfe, 1'b1, 1'b1, 3'b010},   // never a lead byte
      '{8'hff, 1'b1, 1'b1, 3'b010},
      '{8'hc2, 1'b0, 1'b0, 3'b000},   // no-break space, two bytes
      '{8'ha0, 1'b1, 1'b1, 3'b011},
      '{8'hc2, 1'b1, 1'b1, 3'b010},   // sequence still open at end
      '{8'hc3, 1'b0, 1'b0, 3'b000},   // broken continuation
      '{8'h41, 1'b1, 1'b0, 3'b000},
      '{8'he0, 1'b0, 1'b0, 3'b000},   // overlong three-byte form
      '{8'h80, 1'b0, 1'b0, 3'b000},
      '{8'h80, 1'b1, 1'b0, 3'b000},
      '{8'hed, 1'b0, 1'b0, 3'b000},   // surrogate
      '{8'ha0, 1'b0, 1'b0, 3'b000},
      '{8'h80, 1'b1, 1'b0, 3'b000},
      '{8'hef, 1'b0, 1'b0, 3'b000},   // byte order mark
      '{8'hbb, 1'b0, 1'b0, 3'b000},
      '{8'hbf, 1'b1, 1'b0, 3'b000}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   tcv_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   tcv_rsp_type rsp_data;

   feed_entry_type text_feed [$];
   tcv_rsp_type verdict_due [$];
   logic [7:0]  text_piece [$];
   int          fault_count = 0;
   int          send_cycles = 0;
   int          drain_cycles = 0;

   // running verdicts of the string in flight
   logic        seen_ascii = 1'b1;
   logic        seen_latin = 1'b1;
   logic        seen_utf = 1'b1;
   logic [2:0]  cont_left = '0;
   logic [2:0]  seq_len = '0;
   logic [30:0] point_acc = '0;

   text_charset_validator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // tab, lf, cr and the printable range
   function automatic logic plain_char(input logic [30:0] c);
      return (c >= 31'd32 && c <= 31'd126) || c == 31'd9 || c == 31'd10 || c == 31'd13;
   endfunction

   function automatic logic allowed_point(input logic [30:0] c);
      if (plain_char(c)) return 1'b1;
      return c >= 31'd160 && c[30:11] != 20'h0001b && c != 31'h0000feff
             && c != 31'h0000fffe && c != 31'h0000ffff;
   endfunction

   function automatic void restart_string();
      seen_ascii = 1'b1;
      seen_latin = 1'b1;
      seen_utf   = 1'b1;
      cont_left  = '0;
      seq_len    = '0;
      point_acc  = '0;
   endfunction

   // advance the running verdicts by one byte; verdict is valid when done is set
   function automatic void judge_text_byte(input logic [7:0] b, input logic last,
                                           output logic done, output tcv_rsp_type verdict);
      if (!plain_char({23'd0, b})) seen_ascii = 1'b0;
      if (!(plain_char({23'd0, b}) || b >= LATIN_MIN)) seen_latin = 1'b0;

      if (cont_left != 3'd0) begin
         if (b[7:6] != 2'b10) begin
            // broken sequence: drop it, byte not decoded further
            seen_utf  = 1'b0;
            cont_left = '0;
            seq_len   = '0;
            point_acc = '0;
         end else begin
            point_acc = {point_acc[24:0], b[5:0]};
            cont_left = cont_left - 3'd1;
            if (cont_left == 3'd0) begin
               if (!allowed_point(point_acc)) seen_utf = 1'b0;
               if (seq_len >= SEQ_LEN3
                   && point_acc < (31'd1 << (5 * int'(seq_len) - 4))) seen_utf = 1'b0;
               seq_len   = '0;
               point_acc = '0;
            end
         end
      end else if (b < BYTE_ASCII_LIM) begin
         if (!allowed_point({23'd0, b})) seen_utf = 1'b0;
      end else if (b < BYTE_LEAD_MIN || b >= BYTE_BAD_MIN) begin
         seen_utf = 1'b0;
      end else begin
         if (b < BYTE_LEAD3_MIN) begin
            seq_len   = SEQ_LEN2;
            point_acc = {26'd0, b[4:0]};
         end else if (b < BYTE_LEAD4_MIN) begin
            seq_len   = SEQ_LEN3;
            point_acc = {27'd0, b[3:0]};
         end else if (b < BYTE_LEAD5_MIN) begin
            seq_len   = SEQ_LEN4;
            point_acc = {28'd0, b[2:0]};
         end else if (b < BYTE_LEAD6_MIN) begin
            seq_len   = SEQ_LEN5;
            point_acc = {29'd0, b[1:0]};
         end else begin
            seq_len   = SEQ_LEN6;
            point_acc = {30'd0, b[0]};
         end
         cont_left = seq_len - 3'd1;
      end

      done    = last;
      verdict = '0;
      if (last) begin
         if (cont_left != 3'd0) seen_utf = 1'b0;
         verdict.ascii_ok  = seen_ascii;
         verdict.latin1_ok = seen_latin;
         verdict.utf8_ok   = seen_utf;
         restart_string();
      end
   endfunction

   // encode cp as an n-byte sequence, keeping only its first keep bytes
   function automatic void put_sequence(input int n, input int unsigned cp, input int keep);
      logic [7:0] lead_mask;
      lead_mask = 8'hff << (8 - n);
      text_piece.push_back(lead_mask | 8'(cp >> (6 * (n - 1))));
      for (int k = 1; k < keep; k++)
         text_piece.push_back(8'h80 | 8'((cp >> (6 * (n - 1 - k))) & 32'h3f));
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(99, 0);
      if (r < 50) return 2;
      if (r < 80) return 3;
      if (r < 90) return 4;
      if (r < 95) return 5;
      return 6;
   endfunction

   // one random string, mostly well-formed text with some damage mixed in
   task automatic add_string(inout int sent);
      int          units;
      int          r;
      int          n;
      int unsigned lo;
      int unsigned hi;
      text_piece.delete();
      units = $urandom_range(8, 1);
      for (int u = 0; u < units; u++) begin
         r  = $urandom_range(99, 0);
         n  = pick_length();
         lo = (n == 2) ? 32'h80 : (32'h1 << (5 * n - 4));
         hi = (32'h1 << (5 * n + 1)) - 32'h1;
         if (r < 35) begin
            case ($urandom_range(9, 0))
               0:       text_piece.push_back(8'h09);
               1:       text_piece.push_back(8'h0a);
               2:       text_piece.push_back(8'h0d);
               default: text_piece.push_back(8'($urandom_range(126, 32)));
            endcase
         end else if (r < 75) begin
            put_sequence(n, $urandom_range(hi, lo), n);
         end else if (r < 85) begin
            text_piece.push_back(8'($urandom_range(255, 0)));
         end else if (r < 91) begin
            // truncated sequence
            put_sequence(n, $urandom_range(hi, lo), $urandom_range(n - 1, 1));
         end else begin
            case ($urandom_range(4, 0))
               0: put_sequence(n, $urandom_range(lo - 1, 0), n);            // overlong
               1: put_sequence(3, 32'hd800 + $urandom_range(32'h7ff, 0), 3); // surrogate
               2: put_sequence(3, 32'hfeff, 3);
               3: put_sequence(3, $urandom_range(32'hffff, 32'hfffe), 3);
               default: put_sequence(2, $urandom_range(159, 128), 2);     // c1 controls
            endcase
         end
      end
      foreach (text_piece[i]) begin
         feed_entry_type e;
         e.word.text_byte     = text_piece[i];
         e.word.end_of_string = (i == text_piece.size() - 1);
         e.typed              = 1'b0;
         e.want               = '0;
         text_feed.push_back(e);
      end
      sent += text_piece.size();
   endtask

   // byte sender and verdict prediction
   always @(posedge clock) begin
      feed_entry_type taken;
      logic        done;
      tcv_rsp_type verdict;
      logic        idle;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         send_cycles <= send_cycles + 1;
         if (req_valid && !req_stall) begin
            taken = text_feed.pop_front();
            judge_text_byte(taken.word.text_byte, taken.word.end_of_string, done, verdict);
            if (done) verdict_due.push_back(taken.typed ? taken.want : verdict);
         end
         idle = (send_cycles < CALM_FROM || send_cycles > CALM_TO)
                && $urandom_range(99, 0) < IDLE_PERCENT;
         if (req_valid && req_stall) begin
            // hold the word until it is taken
         end else if (text_feed.size() != 0 && !idle) begin
            req_valid <= 1'b1;
            req_data  <= text_feed[0].word;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
         fault_count++;
      end
   endtask

   // verdict receiver, with one long hold-off to back the block up
   always @(posedge clock) begin
      tcv_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         drain_cycles <= drain_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (verdict_due.size() == 0) begin
               $display("%0t: verdict with none expected, expected none, actual %b",
                        $time, rsp_data);
               fault_count++;
            end else begin
               want = verdict_due.pop_front();
               check_field("ascii_ok", want.ascii_ok, rsp_data.ascii_ok);
               check_field("latin1_ok", want.latin1_ok, rsp_data.latin1_ok);
               check_field("utf8_ok", want.utf8_ok, rsp_data.utf8_ok);
            end
         end
         if (drain_cycles >= HOLD_FROM && drain_cycles < HOLD_TO)
            rsp_stall <= 1'b1;
         else if (drain_cycles >= CALM_FROM && drain_cycles <= CALM_TO)
            rsp_stall <= 1'b0;
         else
            rsp_stall <= ($urandom_range(99, 0) < IDLE_PERCENT);
      end
   end

   initial begin
      int sent;
      feed_entry_type e;
      sent = 0;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         e.word.text_byte     = directed_rows[i].text_byte;
         e.word.end_of_string = directed_rows[i].last;
         e.typed              = directed_rows[i].typed;
         e.want               = directed_rows[i].want;
         text_feed.push_back(e);
      end
      while (sent < RANDOM_BYTES) add_string(sent);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // everything sent, then everything answered
      while (text_feed.size() != 0 || req_valid) @(negedge clock);
      while (verdict_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fault_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
